### sv/assert_macros.svh
// Assertion macros for the RTL of the NOR flash command decoder.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define NFCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define NFCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/nfcd_pkg.sv
// Package of the NOR flash command decoder: defaults, command bytes and codes.
// Depends on nothing; used by nfcd_ram and nor_flash_command_decoder_unit.
package nfcd_pkg;

  // Parameter defaults.
  localparam int ADDR_BITS_DEF          = 17;
  localparam int SMALL_SECTOR_BYTES_DEF = 8192;
  localparam int SMALL_SECTORS_DEF      = 8;
  localparam int LARGE_SECTOR_BYTES_DEF = 65536;

  // Fixed field widths.
  localparam int IN_ADDR_W   = 17;
  localparam int DATA_W      = 8;
  localparam int OFFSET_W    = 12;
  localparam int CFG_INDEX_W = 1;

  // Default RAM geometry.
  localparam int RAM_WIDTH_DEF = DATA_W;
  localparam int RAM_DEPTH_DEF = 1 << ADDR_BITS_DEF;

  // Reset values of the unlock offset registers.
  localparam logic [OFFSET_W-1:0] FIRST_UNLOCK_RST  = 12'hAAA;
  localparam logic [OFFSET_W-1:0] SECOND_UNLOCK_RST = 12'h555;

  // Command bytes of the unlock sequences.
  localparam logic [DATA_W-1:0] DATA_UNLOCK1      = 8'hAA;
  localparam logic [DATA_W-1:0] DATA_UNLOCK2      = 8'h55;
  localparam logic [DATA_W-1:0] DATA_PROGRAM      = 8'hA0;
  localparam logic [DATA_W-1:0] DATA_ERASE_SETUP  = 8'h80;
  localparam logic [DATA_W-1:0] DATA_SECTOR_ERASE = 8'h30;
  localparam logic [DATA_W-1:0] DATA_ERASED       = 8'hFF;

  // Bus access kind.
  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } bus_cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FIRST_UNLOCK  = 1'b0,
    CFG_SECOND_UNLOCK = 1'b1
  } cfg_index_t;

  // Command sequencer stage, as reported on the result channel.
  typedef enum logic [2:0] {
    SEQ_IDLE        = 3'd0,
    SEQ_AA          = 3'd1,
    SEQ_55          = 3'd2,
    SEQ_ERASE_SETUP = 3'd3,
    SEQ_AA2         = 3'd4,
    SEQ_552         = 3'd5,
    SEQ_PROGRAM     = 3'd6
  } seq_stage_t;

  // Operation completed by a transaction.
  typedef enum logic [1:0] {
    OP_NONE       = 2'd0,
    OP_PROGRAMMED = 2'd1,
    OP_ERASED     = 2'd2
  } op_done_t;

  // Control state machine of the decoder.
  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_ACCESS,
    CS_FIND,
    CS_ERASE,
    CS_RESP
  } ctl_state_t;

endpackage

### sv/nfcd_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nfcd_pkg for its default geometry.
module nfcd_ram #(
  parameter int WIDTH = nfcd_pkg::RAM_WIDTH_DEF,
  parameter int DEPTH = nfcd_pkg::RAM_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/nor_flash_command_decoder_unit.sv
// Top level of the NOR flash command decoder: sequencer, sector walk, array RAM.
// Depends on nfcd_pkg, nfcd_ram and assert_macros.svh.
//
// Byte-wide NOR flash array with the AMD style unlock command set. Each input
// transaction is one bus read or write and produces exactly one result
// transaction. All array accesses share the single port of the array RAM, so
// one transaction is handled at a time: a read, a program, or any write that
// only steps the sequencer passes through the ACCESS or RESP state before its
// result is registered. A sector erase first walks the sector map (one sector
// boundary per cycle, at most SMALL_SECTORS plus the count of large sectors
// below the address) and then writes 0xFF to every byte of the sector, one
// byte per cycle. After reset the block sweeps the whole array to 0xFF and
// accepts no bus transaction until the sweep is done; configuration writes
// are taken at any time. A finished result waits in an output register, and
// the next transaction is accepted while it waits.
`include "assert_macros.svh"

module nor_flash_command_decoder_unit #(
  parameter int ADDR_BITS          = nfcd_pkg::ADDR_BITS_DEF,
  parameter int SMALL_SECTOR_BYTES = nfcd_pkg::SMALL_SECTOR_BYTES_DEF,
  parameter int SMALL_SECTORS      = nfcd_pkg::SMALL_SECTORS_DEF,
  parameter int LARGE_SECTOR_BYTES = nfcd_pkg::LARGE_SECTOR_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Bus access channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [nfcd_pkg::IN_ADDR_W-1:0]      in_address,
  input  logic [nfcd_pkg::DATA_W-1:0]         in_write_data,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [nfcd_pkg::DATA_W-1:0]         out_read_data,
  output logic [2:0]                          out_sequence_state,
  output logic [1:0]                          out_completed_operation,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [nfcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nfcd_pkg::OFFSET_W-1:0]       cfg_wdata
);

  // Sector arithmetic runs two bits wider than the array so that a sector end
  // past the top of the array still fits.
  localparam int SPAN_W = ADDR_BITS + 2;
  localparam logic [31:0] ARRAY_BYTES = 32'd1 << ADDR_BITS;
  localparam logic [31:0] BOOT_BYTES  = 32'(SMALL_SECTORS * SMALL_SECTOR_BYTES);
  localparam logic [SPAN_W-1:0] ARRAY_SPAN = SPAN_W'(ARRAY_BYTES);
  localparam logic [SPAN_W-1:0] SMALL_SPAN = SPAN_W'(SMALL_SECTOR_BYTES);
  localparam logic [SPAN_W-1:0] LARGE_SPAN = SPAN_W'(LARGE_SECTOR_BYTES);
  localparam logic [ADDR_BITS-1:0] LAST_ADDR = '1;

  nfcd_pkg::ctl_state_t state_r, state_nxt;
  nfcd_pkg::seq_stage_t stage_r, stage_nxt;
  nfcd_pkg::op_done_t   op_nxt;
  nfcd_pkg::op_done_t   done_r;
  nfcd_pkg::seq_stage_t out_seq_r;
  nfcd_pkg::op_done_t   out_done_r;

  logic [nfcd_pkg::OFFSET_W-1:0] first_off_r;
  logic [nfcd_pkg::OFFSET_W-1:0] second_off_r;

  logic                          cmd_r;
  logic [ADDR_BITS-1:0]          addr_r;
  logic [nfcd_pkg::DATA_W-1:0]   data_r;
  logic [nfcd_pkg::DATA_W-1:0]   res_rd_r;
  logic [SPAN_W-1:0]             base_r;
  logic [ADDR_BITS-1:0]          ptr_r;
  logic [ADDR_BITS-1:0]          last_r;
  logic                          out_valid_r;
  logic [nfcd_pkg::DATA_W-1:0]   out_rd_r;

  logic                          in_fire;
  logic                          is_write;
  logic [ADDR_BITS-1:0]          in_addr_ext;
  logic                          at_first;
  logic                          at_second;
  logic                          need_read;
  logic                          start_erase;
  logic                          slot_free;
  logic                          fin;
  logic [nfcd_pkg::DATA_W-1:0]   fin_rd;
  logic                          out_load;
  logic                          erase_last;

  logic [SPAN_W-1:0]             find_size;
  logic [SPAN_W-1:0]             find_end;
  logic [SPAN_W-1:0]             find_lim;
  logic [SPAN_W-1:0]             find_last_w;
  logic                          find_hit;

  logic                          mem_we;
  logic                          mem_re;
  logic [ADDR_BITS-1:0]          mem_addr;
  logic [nfcd_pkg::DATA_W-1:0]   mem_wdata;
  logic [nfcd_pkg::DATA_W-1:0]   mem_rdata;

  // Handshake and address decode of the incoming transaction.
  assign in_ready    = (state_r == nfcd_pkg::CS_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign is_write    = (in_command == nfcd_pkg::CMD_WRITE);
  assign in_addr_ext = ADDR_BITS'(in_address);
  assign at_first    = (in_addr_ext == ADDR_BITS'(first_off_r));
  assign at_second   = (in_addr_ext == ADDR_BITS'(second_off_r));

  // Unlock sequencer: next stage and the operation this write starts.
  always_comb begin
    stage_nxt   = stage_r;
    op_nxt      = nfcd_pkg::OP_NONE;
    start_erase = 1'b0;
    if (in_fire && is_write) begin
      stage_nxt = nfcd_pkg::SEQ_IDLE;
      unique case (stage_r)
        nfcd_pkg::SEQ_IDLE: begin
          if (in_write_data == nfcd_pkg::DATA_UNLOCK1 && at_first) begin
            stage_nxt = nfcd_pkg::SEQ_AA;
          end
        end
        nfcd_pkg::SEQ_AA: begin
          if (in_write_data == nfcd_pkg::DATA_UNLOCK2 && at_second) begin
            stage_nxt = nfcd_pkg::SEQ_55;
          end
        end
        nfcd_pkg::SEQ_55: begin
          if (in_write_data == nfcd_pkg::DATA_PROGRAM && at_first) begin
            stage_nxt = nfcd_pkg::SEQ_PROGRAM;
          end else if (in_write_data == nfcd_pkg::DATA_ERASE_SETUP && at_first) begin
            stage_nxt = nfcd_pkg::SEQ_ERASE_SETUP;
          end
        end
        nfcd_pkg::SEQ_ERASE_SETUP: begin
          if (in_write_data == nfcd_pkg::DATA_UNLOCK1 && at_first) begin
            stage_nxt = nfcd_pkg::SEQ_AA2;
          end
        end
        nfcd_pkg::SEQ_AA2: begin
          if (in_write_data == nfcd_pkg::DATA_UNLOCK2 && at_second) begin
            stage_nxt = nfcd_pkg::SEQ_552;
          end
        end
        nfcd_pkg::SEQ_552: begin
          if (in_write_data == nfcd_pkg::DATA_SECTOR_ERASE) begin
            op_nxt      = nfcd_pkg::OP_ERASED;
            start_erase = 1'b1;
          end
        end
        nfcd_pkg::SEQ_PROGRAM: begin
          op_nxt = nfcd_pkg::OP_PROGRAMMED;
        end
        default: begin
          stage_nxt = nfcd_pkg::SEQ_IDLE;
        end
      endcase
    end
  end

  // Reads and programs need the array byte; programs read, modify and write.
  assign need_read = !is_write || (stage_r == nfcd_pkg::SEQ_PROGRAM);

  // Sector map walk: one sector boundary per cycle until the address is covered.
  assign find_size   = (32'(base_r) < BOOT_BYTES) ? SMALL_SPAN : LARGE_SPAN;
  assign find_end    = base_r + find_size;
  assign find_hit    = (SPAN_W'(addr_r) < find_end);
  assign find_lim    = (find_end > ARRAY_SPAN) ? ARRAY_SPAN : find_end;
  assign find_last_w = find_lim - SPAN_W'(1);

  // Result completion; the output register takes it when it is free.
  assign slot_free  = !out_valid_r || out_ready;
  assign erase_last = (state_r == nfcd_pkg::CS_ERASE) && (ptr_r == last_r);
  assign fin        = (state_r == nfcd_pkg::CS_ACCESS) || erase_last ||
                      (state_r == nfcd_pkg::CS_RESP);
  assign fin_rd     = (state_r == nfcd_pkg::CS_ACCESS && cmd_r == nfcd_pkg::CMD_READ) ?
                      mem_rdata : res_rd_r;
  assign out_load   = fin && slot_free;

  // Control state machine: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nfcd_pkg::CS_CLEAR: begin
        if (ptr_r == LAST_ADDR) begin
          state_nxt = nfcd_pkg::CS_IDLE;
        end
      end
      nfcd_pkg::CS_IDLE: begin
        if (in_fire) begin
          if (need_read) begin
            state_nxt = nfcd_pkg::CS_ACCESS;
          end else if (start_erase) begin
            state_nxt = nfcd_pkg::CS_FIND;
          end else begin
            state_nxt = nfcd_pkg::CS_RESP;
          end
        end
      end
      nfcd_pkg::CS_ACCESS: begin
        state_nxt = slot_free ? nfcd_pkg::CS_IDLE : nfcd_pkg::CS_RESP;
      end
      nfcd_pkg::CS_FIND: begin
        if (find_hit) begin
          state_nxt = nfcd_pkg::CS_ERASE;
        end
      end
      nfcd_pkg::CS_ERASE: begin
        if (erase_last) begin
          state_nxt = slot_free ? nfcd_pkg::CS_IDLE : nfcd_pkg::CS_RESP;
        end
      end
      nfcd_pkg::CS_RESP: begin
        if (slot_free) begin
          state_nxt = nfcd_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = nfcd_pkg::CS_IDLE;
      end
    endcase
  end

  // Control state machine: array port. Only one transaction is in flight, so
  // a program write-back always lands before the next access is issued.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_r;
    mem_wdata = nfcd_pkg::DATA_ERASED;
    unique case (state_r)
      nfcd_pkg::CS_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = ptr_r;
      end
      nfcd_pkg::CS_IDLE: begin
        mem_re   = in_fire && need_read;
        mem_addr = in_addr_ext;
      end
      nfcd_pkg::CS_ACCESS: begin
        mem_we    = (cmd_r == nfcd_pkg::CMD_WRITE);
        mem_wdata = mem_rdata & data_r;
      end
      nfcd_pkg::CS_ERASE: begin
        mem_we   = 1'b1;
        mem_addr = ptr_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nfcd_pkg::CS_CLEAR;
      stage_r      <= nfcd_pkg::SEQ_IDLE;
      first_off_r  <= nfcd_pkg::FIRST_UNLOCK_RST;
      second_off_r <= nfcd_pkg::SECOND_UNLOCK_RST;
      ptr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      if (cfg_we) begin
        case (cfg_index)
          nfcd_pkg::CFG_FIRST_UNLOCK:  first_off_r  <= cfg_wdata;
          nfcd_pkg::CFG_SECOND_UNLOCK: second_off_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == nfcd_pkg::CS_CLEAR || state_r == nfcd_pkg::CS_ERASE) begin
        ptr_r <= ptr_r + ADDR_BITS'(1);
      end else if (state_r == nfcd_pkg::CS_FIND && find_hit) begin
        ptr_r <= base_r[ADDR_BITS-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Transaction and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_command;
      addr_r   <= in_addr_ext;
      data_r   <= in_write_data;
      done_r   <= op_nxt;
      res_rd_r <= '0;
      base_r   <= '0;
    end
    if (state_r == nfcd_pkg::CS_ACCESS) begin
      res_rd_r <= fin_rd;
    end
    if (state_r == nfcd_pkg::CS_FIND) begin
      if (find_hit) begin
        last_r <= find_last_w[ADDR_BITS-1:0];
      end else begin
        base_r <= find_end;
      end
    end
    if (out_load) begin
      out_rd_r   <= fin_rd;
      out_seq_r  <= stage_r;
      out_done_r <= done_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_read_data           = out_rd_r;
  assign out_sequence_state      = out_seq_r;
  assign out_completed_operation = out_done_r;

  // Flash array storage.
  nfcd_ram #(
    .WIDTH (nfcd_pkg::DATA_W),
    .DEPTH (1 << ADDR_BITS)
  ) u_array (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Checks on the sequencer, the program write-back and the erase walk.
  `NFCD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (state_r == nfcd_pkg::CS_CLEAR), "reset did not start the array clear")
  `NFCD_ASSERT(a_prog_writeback, (in_fire && is_write && stage_r == nfcd_pkg::SEQ_PROGRAM) |=> mem_we, "program transaction without write-back")
  `NFCD_ASSERT(a_read_keeps_stage, (in_fire && !is_write) |=> $stable(stage_r), "read changed the sequencer stage")
  `NFCD_ASSERT(a_erase_in_sector, (state_r == nfcd_pkg::CS_ERASE) |-> (ptr_r <= last_r), "erase walked past the sector end")
  `NFCD_ASSERT(a_done_at_idle, (out_valid_r && out_done_r != nfcd_pkg::OP_NONE) |-> (out_seq_r == nfcd_pkg::SEQ_IDLE), "completed operation reported outside idle")

endmodule

### dv/nor_flash_command_decoder_unit_test.sv
// Self-checking testbench for the NOR flash command decoder: bus reads, unlock
// sequences, byte programs and sector erases are predicted and compared per field.
// Depends on nfcd_pkg and the nor_flash_command_decoder_unit RTL.
module nor_flash_command_decoder_unit_test;
  import nfcd_pkg::*;

  localparam int unsigned ARRAY_BYTES  = 1 << ADDR_BITS_DEF;
  localparam int unsigned BOOT_BYTES   = SMALL_SECTORS_DEF * SMALL_SECTOR_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          HOT_SLOTS    = 8;
  localparam int          SETTLE_CYCLES = 20;

  // One result transaction as the decoder should report it.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    seq_stage_t        stage;
    op_done_t          op;
  } access_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_command = 1'b0;
  logic [IN_ADDR_W-1:0]   in_address = '0;
  logic [DATA_W-1:0]      in_write_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DATA_W-1:0]      out_read_data;
  logic [2:0]             out_sequence_state;
  logic [1:0]             out_completed_operation;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [OFFSET_W-1:0]    cfg_wdata = '0;

  // Shadow copy of the device: array contents, sequencer and unlock offsets.
  logic [DATA_W-1:0]   flash_image [0:ARRAY_BYTES-1];
  seq_stage_t          unlock_stage = SEQ_IDLE;
  logic [OFFSET_W-1:0] first_offset = FIRST_UNLOCK_RST;
  logic [OFFSET_W-1:0] second_offset = SECOND_UNLOCK_RST;

  access_result_t pending_responses [$];
  access_result_t oldest_response;
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    items_sent = 0;
  int             sender_idle_pct = 0;
  int             receiver_stall_pct = 0;
  bit             hold_request = 1'b0;
  int             hold_left = 0;
  int             small_erases_left = 20;
  int             large_erases_left = 1;
  logic [IN_ADDR_W-1:0] hot_addr [HOT_SLOTS];

  nor_flash_command_decoder_unit dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_command              (in_command),
    .in_address              (in_address),
    .in_write_data           (in_write_data),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_read_data           (out_read_data),
    .out_sequence_state      (out_sequence_state),
    .out_completed_operation (out_completed_operation),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog: the run must finish well within the cycle budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Each accepted result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        $error("unexpected result: read_data %0h, sequence_state %0d, operation %0d",
               out_read_data, out_sequence_state, out_completed_operation);
        mismatch_count++;
      end else begin
        oldest_response = pending_responses.pop_front();
        if (out_read_data !== oldest_response.read_data) begin
          $error("read_data mismatch: expected %0h, actual %0h",
                 oldest_response.read_data, out_read_data);
          mismatch_count++;
        end
        if (out_sequence_state !== oldest_response.stage) begin
          $error("sequence_state mismatch: expected %0d, actual %0d",
                 oldest_response.stage, out_sequence_state);
          mismatch_count++;
        end
        if (out_completed_operation !== oldest_response.op) begin
          $error("completed_operation mismatch: expected %0d, actual %0d",
                 oldest_response.op, out_completed_operation);
          mismatch_count++;
        end
      end
    end
  end

  // Applies one bus access to the shadow device and returns the expected result.
  function automatic access_result_t flash_response(input bus_cmd_t cmd,
      input logic [IN_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    access_result_t r;
    logic           at_first;
    logic           at_second;
    int unsigned    base;
    int unsigned    span;
    int unsigned    stop;
    at_first  = (addr == IN_ADDR_W'(first_offset));
    at_second = (addr == IN_ADDR_W'(second_offset));
    r.read_data = '0;
    r.op = OP_NONE;
    if (cmd == CMD_READ) begin
      r.read_data = flash_image[addr];
      r.stage = unlock_stage;
    end else begin
      // Any write that is not the next expected step drops back to idle.
      r.stage = SEQ_IDLE;
      case (unlock_stage)
        SEQ_IDLE: if (data == DATA_UNLOCK1 && at_first) r.stage = SEQ_AA;
        SEQ_AA: if (data == DATA_UNLOCK2 && at_second) r.stage = SEQ_55;
        SEQ_55: begin
          if (data == DATA_PROGRAM && at_first) r.stage = SEQ_PROGRAM;
          else if (data == DATA_ERASE_SETUP && at_first) r.stage = SEQ_ERASE_SETUP;
        end
        SEQ_ERASE_SETUP: if (data == DATA_UNLOCK1 && at_first) r.stage = SEQ_AA2;
        SEQ_AA2: if (data == DATA_UNLOCK2 && at_second) r.stage = SEQ_552;
        SEQ_552: begin
          if (data == DATA_SECTOR_ERASE) begin
            // Boot sectors first, then large sectors, clipped to the array end.
            if (addr < BOOT_BYTES) begin
              span = SMALL_SECTOR_BYTES_DEF;
              base = (addr / span) * span;
            end else begin
              span = LARGE_SECTOR_BYTES_DEF;
              base = BOOT_BYTES + ((addr - BOOT_BYTES) / span) * span;
            end
            stop = base + span;
            if (stop > ARRAY_BYTES) stop = ARRAY_BYTES;
            for (int unsigned i = base; i < stop; i++) flash_image[i] = DATA_ERASED;
            r.op = OP_ERASED;
          end
        end
        SEQ_PROGRAM: begin
          flash_image[addr] = flash_image[addr] & data;
          r.op = OP_PROGRAMMED;
        end
        default: ;
      endcase
    end
    unlock_stage = r.stage;
    return r;
  endfunction

  // Revisits a small pool of addresses half of the time so reads see programmed bytes.
  function automatic logic [IN_ADDR_W-1:0] pick_address();
    int slot;
    slot = $urandom_range(HOT_SLOTS - 1);
    if ($urandom_range(9) == 0) hot_addr[slot] = IN_ADDR_W'($urandom);
    if ($urandom_range(1) == 0) return hot_addr[slot];
    return IN_ADDR_W'($urandom);
  endfunction

  // Offers one bus transaction and records its prediction once accepted.
  task automatic send_access(input bus_cmd_t cmd, input logic [IN_ADDR_W-1:0] addr,
      input logic [DATA_W-1:0] data);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_responses.push_back(flash_response(cmd, addr, data));
    items_sent++;
  endtask

  // Stops offering transactions until every predicted result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  // Writes both unlock offsets while the decoder is idle.
  task automatic set_unlock_offsets(input logic [OFFSET_W-1:0] first,
      input logic [OFFSET_W-1:0] second);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_FIRST_UNLOCK;
    cfg_wdata <= first;
    @(posedge clk);
    first_offset = first;
    cfg_index <= CFG_SECOND_UNLOCK;
    cfg_wdata <= second;
    @(posedge clk);
    second_offset = second;
    cfg_we <= 1'b0;
  endtask

  // Sends a program or sector erase command sequence. With break_at >= 0 the
  // sequence stops at that step, which is corrupted in data or address.
  task automatic send_unlock_steps(input bit erase, input logic [IN_ADDR_W-1:0] target,
      input logic [DATA_W-1:0] data, input int break_at, input int read_pct);
    logic [IN_ADDR_W-1:0] step_addr [6];
    logic [DATA_W-1:0]    step_data [6];
    logic [IN_ADDR_W-1:0] f;
    logic [IN_ADDR_W-1:0] s;
    int                   steps;
    f = IN_ADDR_W'(first_offset);
    s = IN_ADDR_W'(second_offset);
    step_addr[0] = f;
    step_data[0] = DATA_UNLOCK1;
    step_addr[1] = s;
    step_data[1] = DATA_UNLOCK2;
    if (erase) begin
      step_addr[2] = f;
      step_data[2] = DATA_ERASE_SETUP;
      step_addr[3] = f;
      step_data[3] = DATA_UNLOCK1;
      step_addr[4] = s;
      step_data[4] = DATA_UNLOCK2;
      step_addr[5] = target;
      step_data[5] = DATA_SECTOR_ERASE;
      steps = 6;
    end else begin
      step_addr[2] = f;
      step_data[2] = DATA_PROGRAM;
      step_addr[3] = target;
      step_data[3] = data;
      steps = 4;
    end
    if (break_at >= 0) begin
      steps = break_at + 1;
      // The erase confirm takes any address, so only its data can be wrong.
      if ((erase && break_at == 5) || $urandom_range(1) == 0)
        step_data[break_at] ^= DATA_W'($urandom_range(255, 1));
      else
        step_addr[break_at] ^= IN_ADDR_W'(1) << $urandom_range(IN_ADDR_W - 1);
    end
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(99) < read_pct)
        send_access(CMD_READ, pick_address(), DATA_W'($urandom));
      send_access(CMD_WRITE, step_addr[i], step_data[i]);
    end
  endtask

  // Reads at the array ends, a program with a read in the middle of the
  // sequence, and a second program over the same byte that can only clear bits.
  task automatic test_program_path();
    send_access(CMD_READ, '0, '0);
    send_access(CMD_WRITE, IN_ADDR_W'(first_offset), DATA_UNLOCK1);
    send_access(CMD_WRITE, IN_ADDR_W'(second_offset), DATA_UNLOCK2);
    send_access(CMD_READ, '1, 8'hFF);
    send_access(CMD_WRITE, IN_ADDR_W'(first_offset), DATA_PROGRAM);
    send_access(CMD_WRITE, '1, 8'h5A);
    send_unlock_steps(1'b0, '1, 8'hA5, -1, 0);
    send_access(CMD_READ, '1, '0);
    send_access(CMD_WRITE, '0, 8'hFF);
  endtask

  // The whole address must match, and a stray unlock byte does not restart.
  task automatic test_unlock_matching();
    send_access(CMD_WRITE, IN_ADDR_W'(first_offset) | (IN_ADDR_W'(1) << (IN_ADDR_W - 1)),
                DATA_UNLOCK1);
    send_access(CMD_WRITE, IN_ADDR_W'(first_offset), DATA_UNLOCK1);
    send_access(CMD_WRITE, IN_ADDR_W'(first_offset), DATA_UNLOCK1);
    send_access(CMD_WRITE, IN_ADDR_W'(second_offset), DATA_UNLOCK2);
  endtask

  // Erases the top large sector, then checks that a lone erase confirm is ignored.
  task automatic test_sector_erase();
    send_unlock_steps(1'b1, '1, '0, -1, 0);
    send_access(CMD_READ, '1, '0);
    send_access(CMD_WRITE, '0, DATA_SECTOR_ERASE);
  endtask

  // The receiver holds off long enough for the decoder to stall its input.
  task automatic test_back_pressure();
    wait_for_results();
    hold_request = 1'b1;
    repeat (16) send_access(CMD_READ, pick_address(), DATA_W'($urandom));
    wait_for_results();
  endtask

  // Mostly well-formed command sequences with random content, plus broken
  // sequences, plain reads and stray writes of command bytes.
  task automatic run_command_mix(input int unsigned count);
    int unsigned          start;
    int                   pick;
    bit                   erase;
    logic [IN_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]    data;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(99);
      addr = pick_address();
      if (pick < 40) begin
        send_unlock_steps(1'b0, addr, DATA_W'($urandom | $urandom), -1, 15);
      end else if (pick < 48) begin
        // Erases are slow, so most of them hit the small boot sectors.
        if (large_erases_left > 0 && $urandom_range(9) == 0) begin
          large_erases_left--;
          send_unlock_steps(1'b1, IN_ADDR_W'(BOOT_BYTES + $urandom_range(BOOT_BYTES - 1)),
                            '0, -1, 15);
        end else if (small_erases_left > 0) begin
          small_erases_left--;
          if (addr >= BOOT_BYTES) addr = IN_ADDR_W'($urandom_range(BOOT_BYTES - 1));
          send_unlock_steps(1'b1, addr, '0, -1, 15);
        end else begin
          send_unlock_steps(1'b1, addr, '0, 5, 15);
        end
      end else if (pick < 63) begin
        erase = $urandom_range(1);
        send_unlock_steps(erase, addr, DATA_W'($urandom), $urandom_range(erase ? 5 : 2), 15);
      end else if (pick < 85) begin
        send_access(CMD_READ, addr, DATA_W'($urandom));
      end else begin
        case ($urandom_range(5))
          0: data = DATA_UNLOCK1;
          1: data = DATA_UNLOCK2;
          2: data = DATA_ERASE_SETUP;
          3: data = DATA_PROGRAM;
          4: data = DATA_SECTOR_ERASE;
          default: data = DATA_W'($urandom);
        endcase
        case ($urandom_range(2))
          0: addr = IN_ADDR_W'(first_offset);
          1: addr = IN_ADDR_W'(second_offset);
          default: ;
        endcase
        send_access(CMD_WRITE, addr, data);
      end
    end
  endtask

  // Random phases, each with its own unlock offsets and idling pattern.
  task automatic test_random_traffic();
    logic [OFFSET_W-1:0] shared;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          set_unlock_offsets('0, '1);
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          set_unlock_offsets('1, '0);
          sender_idle_pct = 61;
          receiver_stall_pct = 0;
        end
        2: begin
          set_unlock_offsets(OFFSET_W'($urandom), OFFSET_W'($urandom));
          sender_idle_pct = 0;
          receiver_stall_pct = 61;
        end
        3: begin
          // Both unlock steps at the same address.
          shared = OFFSET_W'($urandom);
          set_unlock_offsets(shared, shared);
          sender_idle_pct = 31;
          receiver_stall_pct = 31;
        end
        default: begin
          set_unlock_offsets(FIRST_UNLOCK_RST, SECOND_UNLOCK_RST);
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
      endcase
      run_command_mix(340);
    end
  endtask

  initial begin
    for (int unsigned i = 0; i < ARRAY_BYTES; i++) flash_image[i] = DATA_ERASED;
    for (int i = 0; i < HOT_SLOTS; i++) hot_addr[i] = IN_ADDR_W'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_program_path();
    test_unlock_matching();
    test_sector_erase();
    test_back_pressure();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
